// ===== sv/absme_pkg.sv =====
package absme_pkg;

	localparam int REC_BYTES = 32;
	localparam int CRC_SPAN = 28;
	localparam int CRC_POS = 28;
	localparam int BOOT_MARK_POS = 16;
	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;
	localparam logic [7:0] MAX_PRIO = 8'd15;
	localparam logic [7:0] MAX_TRIES = 8'd7;
	localparam logic [7:0] MAGIC_0 = 8'h00;
	localparam logic [7:0] MAGIC_1 = 8'h41;
	localparam logic [7:0] MAGIC_2 = 8'h42;
	localparam logic [7:0] MAGIC_3 = 8'h30;

	typedef enum logic [2:0] {
		ACT_WRITE    = 3'd0,
		ACT_READ     = 3'd1,
		ACT_VALIDATE = 3'd2,
		ACT_PRIMARY  = 3'd3,
		ACT_BAD      = 3'd4,
		ACT_GOOD     = 3'd5,
		ACT_QUERY    = 3'd6,
		ACT_NOP      = 3'd7
	} act_t;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_MAGIC      = 4'd1,
		ST_VERSION    = 4'd2,
		ST_CRC        = 4'd3,
		ST_FIELDS     = 4'd4,
		ST_BOOT_MARK  = 4'd5,
		ST_UNKNOWN    = 4'd6,
		ST_PEER_UNB   = 4'd7,
		ST_NOT_CUR    = 4'd8,
		ST_UNBOOTABLE = 4'd9,
		ST_ALREADY    = 4'd10
	} status_t;

	typedef struct packed {
		act_t        action;
		logic        slot;
		logic        current_slot;
		logic        current_known;
		logic [4:0]  byte_index;
		logic [7:0]  byte_value;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  read_data;
		logic        lead_slot;
		logic        primary_exists;
		logic [1:0]  class_slot_a;
		logic [1:0]  class_slot_b;
		logic [31:0] crc_value;
	} res_t;

	typedef enum logic [1:0] {
		MUT_PRIMARY,
		MUT_BAD,
		MUT_GOOD
	} mut_op_t;

	typedef struct packed {
		logic    en;
		mut_op_t op;
		logic    slot;
	} mut_cmd_t;

	typedef struct packed {
		logic        en;
		logic [31:0] crc;
	} seal_cmd_t;

	typedef struct packed {
		logic [1:0][7:0] prio;
		logic [1:0][7:0] tries;
		logic [1:0][7:0] succ;
		logic [7:0]      boot_mark;
		logic            magic_ok;
		logic            version_ok;
		logic [31:0]     sealed_crc;
	} rec_view_t;

	function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
		logic [31:0] c;
		c = {24'd0, idx};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== sv/absme_crc_unit.sv =====
module absme_crc_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        step,
	input  logic [7:0]  data,
	output logic [31:0] crc_final
);
	import absme_pkg::*;

	logic [31:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (clear) begin
			crc_q <= CRC_INIT;
		end else if (step) begin
			crc_q <= (crc_q >> 8) ^ crc_table_entry(crc_q[7:0] ^ data);
		end
	end

	assign crc_final = ~crc_q;

endmodule

// ===== sv/absme_record.sv =====
module absme_record (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [4:0]           wr_idx,
	input  logic [7:0]           wr_data,
	input  absme_pkg::mut_cmd_t  mut,
	input  absme_pkg::seal_cmd_t seal,
	input  logic [4:0]           rd_idx,
	output logic [7:0]           rd_data,
	output absme_pkg::rec_view_t view
);
	import absme_pkg::*;

	logic [7:0] rec_q [REC_BYTES];
	logic [4:0] t_prio;
	logic [4:0] t_tries;
	logic [4:0] t_succ;
	logic [4:0] t_flags;
	logic [4:0] o_prio;

	assign t_prio  = {2'b01, mut.slot, 2'd0};
	assign t_tries = {2'b01, mut.slot, 2'd1};
	assign t_succ  = {2'b01, mut.slot, 2'd2};
	assign t_flags = {2'b01, mut.slot, 2'd3};
	assign o_prio  = {2'b01, ~mut.slot, 2'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REC_BYTES; i++) begin
				rec_q[i] <= '0;
			end
		end else begin
			if (wr_en) begin
				rec_q[wr_idx] <= wr_data;
			end
			if (mut.en) begin
				unique case (mut.op)
					MUT_PRIMARY: begin
						rec_q[t_prio]  <= MAX_PRIO;
						rec_q[t_tries] <= MAX_TRIES;
						rec_q[t_succ]  <= 8'd0;
						if (rec_q[o_prio] == MAX_PRIO) begin
							rec_q[o_prio] <= MAX_PRIO - 8'd1;
						end
					end
					MUT_BAD: begin
						rec_q[t_prio]  <= 8'd0;
						rec_q[t_tries] <= 8'd0;
						rec_q[t_succ]  <= 8'd0;
					end
					MUT_GOOD: begin
						rec_q[t_prio]  <= MAX_PRIO;
						rec_q[t_tries] <= 8'd0;
						rec_q[t_succ]  <= 8'd1;
						rec_q[t_flags] <= rec_q[t_flags] & 8'hfe;
						rec_q[BOOT_MARK_POS] <= {7'd0, mut.slot};
					end
					default: begin
					end
				endcase
			end
			if (seal.en) begin
				rec_q[CRC_POS]     <= seal.crc[31:24];
				rec_q[CRC_POS + 1] <= seal.crc[23:16];
				rec_q[CRC_POS + 2] <= seal.crc[15:8];
				rec_q[CRC_POS + 3] <= seal.crc[7:0];
			end
		end
	end

	assign rd_data = rec_q[rd_idx];

	always_comb begin
		for (int s = 0; s < 2; s++) begin
			view.prio[s]  = rec_q[8 + 4 * s];
			view.tries[s] = rec_q[9 + 4 * s];
			view.succ[s]  = rec_q[10 + 4 * s];
		end
		view.boot_mark  = rec_q[BOOT_MARK_POS];
		view.magic_ok   = (rec_q[0] == MAGIC_0) && (rec_q[1] == MAGIC_1)
			&& (rec_q[2] == MAGIC_2) && (rec_q[3] == MAGIC_3);
		view.version_ok = (rec_q[4] == 8'd1) && (rec_q[5] == 8'd0);
		view.sealed_crc = {rec_q[CRC_POS], rec_q[CRC_POS + 1],
			rec_q[CRC_POS + 2], rec_q[CRC_POS + 3]};
	end

endmodule

// ===== sv/ab_boot_slot_metadata_engine.sv =====
// Each transaction is taken when start is high and busy is low; busy then stays high until the
// result has been produced. One byte-wide CRC-32 unit is stepped once per record byte over bytes
// 0 to 27; a set-primary, mark-bad or mark-good that changes the record must then reseal it
// with a second pass over the same bytes. The result appears
// on result for exactly one cycle with done high, and the receiver cannot stall it; a new
// transaction may be started in that same cycle. The record is all zero after reset.
module ab_boot_slot_metadata_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  absme_pkg::cmd_t command,
	output logic            done,
	output absme_pkg::res_t result
);
	import absme_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRE,
		S_CRC,
		S_POST
	} state_t;

	typedef enum logic [1:0] {
		P_FINAL,
		P_CHECK,
		P_SEAL
	} purpose_t;

	state_t      state_q;
	purpose_t    purpose_q;
	cmd_t        cmd_q;
	status_t     status_q;
	logic [7:0]  rd_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	res_t        result_q;

	logic        crc_clear;
	logic        crc_step;
	logic [31:0] crc_final;
	logic        wr_en;
	mut_cmd_t    mut;
	seal_cmd_t   seal;
	logic [4:0]  rd_idx;
	logic [7:0]  rd_data;
	rec_view_t   view;

	logic        is_mut;
	logic        boot_a;
	logic        boot_b;
	logic        boot_t;
	logic        boot_o;
	status_t     chk_status;
	status_t     mut_status;
	logic        mut_apply;
	mut_op_t     mut_op;
	logic        reseal;

	function automatic logic slot_bootable(input logic [7:0] pr, input logic [7:0] tr,
		input logic [7:0] sb);
		return (pr != 8'd0) && ((sb != 8'd0) || (tr != 8'd0));
	endfunction

	function automatic logic [1:0] slot_class(input logic [7:0] pr, input logic [7:0] tr,
		input logic [7:0] sb);
		logic bt;
		bt = slot_bootable(pr, tr, sb);
		if ((pr != 8'd0) && (tr == 8'd0) && (sb == 8'd1) && bt) begin
			return 2'd0;
		end else if ((pr != 8'd0) && (tr != 8'd0) && (sb == 8'd0) && bt) begin
			return 2'd1;
		end else if ((pr == 8'd0) && (tr == 8'd0) && (sb == 8'd0) && !bt) begin
			return 2'd2;
		end
		return 2'd3;
	endfunction

	absme_crc_unit u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (crc_clear),
		.step      (crc_step),
		.data      (rd_data),
		.crc_final (crc_final)
	);

	absme_record u_record (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (cmd_q.byte_index),
		.wr_data (cmd_q.byte_value),
		.mut     (mut),
		.seal    (seal),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.view    (view)
	);

	assign is_mut = (cmd_q.action == ACT_PRIMARY) || (cmd_q.action == ACT_BAD)
		|| (cmd_q.action == ACT_GOOD);
	assign boot_a = slot_bootable(view.prio[0], view.tries[0], view.succ[0]);
	assign boot_b = slot_bootable(view.prio[1], view.tries[1], view.succ[1]);
	assign boot_t = cmd_q.slot ? boot_b : boot_a;
	assign boot_o = cmd_q.slot ? boot_a : boot_b;

	always_comb begin
		priority if (!view.magic_ok) begin
			chk_status = ST_MAGIC;
		end else if (!view.version_ok) begin
			chk_status = ST_VERSION;
		end else if (view.sealed_crc != crc_final) begin
			chk_status = ST_CRC;
		end else if ((view.prio[0] > MAX_PRIO) || (view.tries[0] > MAX_TRIES)
			|| (view.succ[0] > 8'd1) || (view.prio[1] > MAX_PRIO)
			|| (view.tries[1] > MAX_TRIES) || (view.succ[1] > 8'd1)) begin
			chk_status = ST_FIELDS;
		end else if (view.boot_mark > 8'd1) begin
			chk_status = ST_BOOT_MARK;
		end else begin
			chk_status = ST_OK;
		end
	end

	always_comb begin
		mut_status = ST_OK;
		mut_apply  = 1'b0;
		mut_op     = MUT_PRIMARY;
		unique case (cmd_q.action)
			ACT_PRIMARY: begin
				mut_apply = 1'b1;
			end
			ACT_BAD: begin
				mut_op = MUT_BAD;
				priority if (!boot_o) begin
					mut_status = ST_PEER_UNB;
				end else if ((view.prio[cmd_q.slot] == 8'd0)
					&& (view.tries[cmd_q.slot] == 8'd0)
					&& (view.succ[cmd_q.slot] == 8'd0)) begin
					mut_status = ST_ALREADY;
				end else begin
					mut_apply = 1'b1;
				end
			end
			ACT_GOOD: begin
				mut_op = MUT_GOOD;
				priority if (cmd_q.slot != cmd_q.current_slot) begin
					mut_status = ST_NOT_CUR;
				end else if (!boot_t) begin
					mut_status = ST_UNBOOTABLE;
				end else begin
					mut_apply = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign reseal = (state_q == S_POST) && (purpose_q == P_CHECK) && is_mut
		&& (chk_status == ST_OK) && mut_apply;

	always_comb begin
		crc_clear = (state_q == S_PRE) || reseal;
		crc_step  = (state_q == S_CRC);
		wr_en     = (state_q == S_PRE) && (cmd_q.action == ACT_WRITE);
		rd_idx    = (state_q == S_PRE) ? cmd_q.byte_index : cnt_q;
		mut.en    = reseal;
		mut.op    = mut_op;
		mut.slot  = cmd_q.slot;
		seal.en   = (state_q == S_POST) && (purpose_q == P_SEAL);
		seal.crc  = crc_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			purpose_q <= P_FINAL;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			rd_q      <= '0;
			cmd_q     <= '0;
			result_q  <= '0;
		end else begin
			done_q <= (state_q == S_POST) && !reseal;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					status_q  <= (is_mut && !cmd_q.current_known) ? ST_UNKNOWN : ST_OK;
					rd_q      <= (cmd_q.action == ACT_READ) ? rd_data : 8'd0;
					cnt_q     <= '0;
					state_q   <= S_CRC;
					purpose_q <= ((cmd_q.action == ACT_VALIDATE)
						|| (cmd_q.action == ACT_QUERY)
						|| (is_mut && cmd_q.current_known)) ? P_CHECK : P_FINAL;
				end
				S_CRC: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(CRC_SPAN - 1)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (reseal) begin
						cnt_q     <= '0;
						purpose_q <= P_SEAL;
						state_q   <= S_CRC;
					end else begin
						state_q                 <= S_IDLE;
						result_q.status         <= (purpose_q == P_CHECK)
							? ((is_mut && (chk_status == ST_OK)) ? mut_status : chk_status)
							: status_q;
						result_q.read_data      <= rd_q;
						result_q.primary_exists <= boot_a || boot_b;
						result_q.lead_slot      <= (boot_a && boot_b)
							? (view.prio[1] > view.prio[0]) : boot_b;
						result_q.class_slot_a   <= slot_class(view.prio[0], view.tries[0],
							view.succ[0]);
						result_q.class_slot_b   <= slot_class(view.prio[1], view.tries[1],
							view.succ[1]);
						result_q.crc_value      <= crc_final;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== tb/tb.sv =====
module tb;
	import absme_pkg::*;

	localparam int SLOT_BASE = 8;
	localparam logic [7:0] VER_MAJOR = 8'd1;
	localparam logic [7:0] VER_MINOR = 8'd0;
	localparam logic [1:0] CLS_GOOD = 2'd0;
	localparam logic [1:0] CLS_PENDING = 2'd1;
	localparam logic [1:0] CLS_BAD = 2'd2;
	localparam logic [1:0] CLS_MIXED = 2'd3;

	typedef struct packed {
		logic drain;
		cmd_t c;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t command = '0;
	logic busy;
	logic done;
	res_t result;

	logic [7:0] rec_img [32];
	pend_t cmd_backlog[$];
	res_t slot_reports_due[$];
	int n_accepted = 0;
	int n_refused = 0;
	int in_flight = 0;
	int mismatches = 0;
	int burst_left = 8;
	int gap_left = 0;
	int total_items = 0;

	ab_boot_slot_metadata_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] crc32_of(input logic [7:0] img [32]);
		logic [31:0] c;
		c = CRC_INIT;
		for (int i = 0; i < CRC_SPAN; i++) begin
			c ^= {24'd0, img[i]};
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
		end
		return ~c;
	endfunction

	function automatic bit slot_boots(input logic s);
		int b;
		b = SLOT_BASE + 4 * int'(s);
		return rec_img[b] != 0 && (rec_img[b + 2] != 0 || rec_img[b + 1] != 0);
	endfunction

	function automatic logic [1:0] slot_class_of(input logic s);
		int b;
		logic [7:0] pr, tr, sb;
		bit bt;
		b = SLOT_BASE + 4 * int'(s);
		pr = rec_img[b];
		tr = rec_img[b + 1];
		sb = rec_img[b + 2];
		bt = slot_boots(s);
		if (pr != 0 && tr == 0 && sb == 1 && bt) return CLS_GOOD;
		if (pr != 0 && tr != 0 && sb == 0 && bt) return CLS_PENDING;
		if (pr == 0 && tr == 0 && sb == 0 && !bt) return CLS_BAD;
		return CLS_MIXED;
	endfunction

	function automatic status_t record_check();
		logic [31:0] stored;
		int b;
		if (rec_img[0] != MAGIC_0 || rec_img[1] != MAGIC_1 || rec_img[2] != MAGIC_2 ||
				rec_img[3] != MAGIC_3) return ST_MAGIC;
		if (rec_img[4] != VER_MAJOR || rec_img[5] != VER_MINOR) return ST_VERSION;
		stored = {rec_img[CRC_POS], rec_img[CRC_POS + 1], rec_img[CRC_POS + 2],
			rec_img[CRC_POS + 3]};
		if (stored != crc32_of(rec_img)) return ST_CRC;
		for (int s = 0; s < 2; s++) begin
			b = SLOT_BASE + 4 * s;
			if (rec_img[b] > MAX_PRIO || rec_img[b + 1] > MAX_TRIES || rec_img[b + 2] > 1)
				return ST_FIELDS;
		end
		if (rec_img[BOOT_MARK_POS] > 1) return ST_BOOT_MARK;
		return ST_OK;
	endfunction

	function automatic status_t apply_slot_change(input cmd_t c);
		int t, o;
		status_t st;
		logic [31:0] seal;
		t = SLOT_BASE + 4 * int'(c.slot);
		o = SLOT_BASE + 4 * int'(!c.slot);
		if (!c.current_known) return ST_UNKNOWN;
		st = record_check();
		if (st != ST_OK) return st;
		case (c.action)
		ACT_PRIMARY: begin
			rec_img[t] = MAX_PRIO;
			rec_img[t + 1] = MAX_TRIES;
			rec_img[t + 2] = 8'd0;
			if (rec_img[o] == MAX_PRIO) rec_img[o] = MAX_PRIO - 8'd1;
		end
		ACT_BAD: begin
			if (!slot_boots(!c.slot)) return ST_PEER_UNB;
			if (rec_img[t] == 0 && rec_img[t + 1] == 0 && rec_img[t + 2] == 0)
				return ST_ALREADY;
			rec_img[t] = 8'd0;
			rec_img[t + 1] = 8'd0;
			rec_img[t + 2] = 8'd0;
		end
		default: begin
			if (c.slot != c.current_slot) return ST_NOT_CUR;
			if (!slot_boots(c.slot)) return ST_UNBOOTABLE;
			rec_img[t] = MAX_PRIO;
			rec_img[t + 1] = 8'd0;
			rec_img[t + 2] = 8'd1;
			rec_img[t + 3][0] = 1'b0;
			rec_img[BOOT_MARK_POS] = {7'd0, c.slot};
		end
		endcase
		seal = crc32_of(rec_img);
		rec_img[CRC_POS] = seal[31:24];
		rec_img[CRC_POS + 1] = seal[23:16];
		rec_img[CRC_POS + 2] = seal[15:8];
		rec_img[CRC_POS + 3] = seal[7:0];
		return ST_OK;
	endfunction

	function automatic res_t engine_outcome(input cmd_t c);
		res_t r;
		bit a, b;
		r = '0;
		case (c.action)
		ACT_WRITE: rec_img[c.byte_index] = c.byte_value;
		ACT_READ: r.read_data = rec_img[c.byte_index];
		ACT_VALIDATE, ACT_QUERY: r.status = record_check();
		ACT_PRIMARY, ACT_BAD, ACT_GOOD: r.status = apply_slot_change(c);
		default: ;
		endcase
		a = slot_boots(1'b0);
		b = slot_boots(1'b1);
		r.primary_exists = a || b;
		if (a && b) r.lead_slot = rec_img[SLOT_BASE + 4] > rec_img[SLOT_BASE];
		else r.lead_slot = b;
		r.class_slot_a = slot_class_of(1'b0);
		r.class_slot_b = slot_class_of(1'b1);
		r.crc_value = crc32_of(rec_img);
		return r;
	endfunction

	function automatic void plan(input act_t a, input logic s, input logic cs, input logic ck,
			input logic [4:0] idx, input logic [7:0] v, input logic drain);
		pend_t p;
		p.drain = drain;
		p.c.action = a;
		p.c.slot = s;
		p.c.current_slot = cs;
		p.c.current_known = ck;
		p.c.byte_index = idx;
		p.c.byte_value = v;
		cmd_backlog.push_back(p);
	endfunction

	always @(posedge clk) begin : drive_proc
		res_t r;
		if (arst_n) begin
			if (start && !busy) begin
				r = engine_outcome(command);
				slot_reports_due.push_back(r);
				n_accepted++;
				in_flight++;
				if (r.status != ST_OK) n_refused++;
			end
			if (done) in_flight--;
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() == 0 ||
						(cmd_backlog[0].drain && in_flight != 0)) begin
					start <= 1'b0;
				end else begin
					command <= cmd_backlog[0].c;
					cmd_backlog.pop_front();
					start <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : check_proc
		res_t w;
		if (arst_n && done) begin
			if (slot_reports_due.size() == 0) begin
				$error("tb: result with no transaction outstanding");
				mismatches++;
			end else begin
				w = slot_reports_due.pop_front();
				if (result.status !== w.status) begin
					$error("status expected %0d got %0d", w.status, result.status);
					mismatches++;
				end
				if (result.read_data !== w.read_data) begin
					$error("read_data expected %0h got %0h", w.read_data, result.read_data);
					mismatches++;
				end
				if (result.lead_slot !== w.lead_slot) begin
					$error("lead_slot expected %0d got %0d", w.lead_slot,
						result.lead_slot);
					mismatches++;
				end
				if (result.primary_exists !== w.primary_exists) begin
					$error("primary_exists expected %0d got %0d", w.primary_exists,
						result.primary_exists);
					mismatches++;
				end
				if (result.class_slot_a !== w.class_slot_a) begin
					$error("class_slot_a expected %0d got %0d", w.class_slot_a,
						result.class_slot_a);
					mismatches++;
				end
				if (result.class_slot_b !== w.class_slot_b) begin
					$error("class_slot_b expected %0d got %0d", w.class_slot_b,
						result.class_slot_b);
					mismatches++;
				end
				if (result.crc_value !== w.crc_value) begin
					$error("crc_value expected %08h got %08h", w.crc_value, result.crc_value);
					mismatches++;
				end
			end
		end
	end

	initial begin : stim_proc
		logic [7:0] img [32];
		logic [31:0] seal;
		logic run_slot;
		int n, pick, b;
		act_t a;
		for (int i = 0; i < REC_BYTES; i++) rec_img[i] = 8'd0;

		// Directed: empty record, unused code, unknown identity, then the early checks.
		plan(ACT_QUERY, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0, 1'b0);
		plan(ACT_READ, 1'b1, 1'b1, 1'b1, 5'd31, 8'hff, 1'b0);
		plan(ACT_NOP, 1'b1, 1'b1, 1'b1, 5'd31, 8'hff, 1'b0);
		plan(ACT_GOOD, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0, 1'b0);
		plan(ACT_PRIMARY, 1'b1, 1'b0, 1'b1, 5'd0, 8'd0, 1'b0);
		plan(ACT_WRITE, 1'b0, 1'b0, 1'b0, 5'd0, 8'hff, 1'b0);
		plan(ACT_VALIDATE, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0, 1'b0);
		plan(ACT_WRITE, 1'b0, 1'b0, 1'b0, 5'd0, MAGIC_0, 1'b0);
		plan(ACT_WRITE, 1'b0, 1'b0, 1'b0, 5'd1, MAGIC_1, 1'b0);
		plan(ACT_WRITE, 1'b0, 1'b0, 1'b0, 5'd2, MAGIC_2, 1'b0);
		plan(ACT_WRITE, 1'b0, 1'b0, 1'b0, 5'd3, MAGIC_3, 1'b0);
		plan(ACT_VALIDATE, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0, 1'b0);
		plan(ACT_WRITE, 1'b0, 1'b0, 1'b0, 5'd4, VER_MAJOR, 1'b0);
		plan(ACT_BAD, 1'b0, 1'b0, 1'b1, 5'd0, 8'd0, 1'b0);
		plan(ACT_WRITE, 1'b0, 1'b0, 1'b0, 5'd5, 8'hff, 1'b0);
		plan(ACT_QUERY, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0, 1'b0);
		plan(ACT_WRITE, 1'b0, 1'b0, 1'b0, 5'd5, VER_MINOR, 1'b0);
		plan(ACT_READ, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0, 1'b0);

		// Random: load a sealed record, then run slot commands against it.
		while (cmd_backlog.size() < 380) begin
			img[0] = MAGIC_0;
			img[1] = MAGIC_1;
			img[2] = MAGIC_2;
			img[3] = MAGIC_3;
			img[4] = VER_MAJOR;
			img[5] = VER_MINOR;
			for (int i = 6; i < CRC_POS; i++) img[i] = 8'($urandom);
			for (int s = 0; s < 2; s++) begin
				b = SLOT_BASE + 4 * s;
				img[b] = ($urandom_range(0, 3) == 0) ? 8'd0 :
					(($urandom_range(0, 2) == 0) ? MAX_PRIO : 8'($urandom_range(1, 15)));
				img[b + 1] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 7));
				img[b + 2] = 8'($urandom_range(0, 1));
			end
			img[BOOT_MARK_POS] = 8'($urandom_range(0, 1));
			if ($urandom_range(0, 6) == 0) begin
				b = SLOT_BASE + 4 * $urandom_range(0, 1);
				case ($urandom_range(0, 3))
				0: img[b] = 8'($urandom_range(16, 255));
				1: img[b + 1] = 8'($urandom_range(8, 255));
				2: img[b + 2] = 8'($urandom_range(2, 255));
				default: img[BOOT_MARK_POS] = 8'($urandom_range(2, 255));
				endcase
			end
			seal = crc32_of(img);
			img[CRC_POS] = seal[31:24];
			img[CRC_POS + 1] = seal[23:16];
			img[CRC_POS + 2] = seal[15:8];
			img[CRC_POS + 3] = seal[7:0];
			for (int i = 0; i < REC_BYTES; i++)
				plan(ACT_WRITE, 1'($urandom), 1'($urandom), 1'($urandom), 5'(i), img[i], i == 0);
			run_slot = 1'($urandom);
			n = $urandom_range(6, 30);
			repeat (n) begin
				pick = $urandom_range(0, 19);
				if (pick < 4) a = ACT_PRIMARY;
				else if (pick < 8) a = ACT_BAD;
				else if (pick < 12) a = ACT_GOOD;
				else if (pick < 14) a = ACT_QUERY;
				else if (pick < 15) a = ACT_VALIDATE;
				else if (pick < 18) a = ACT_READ;
				else if (pick < 19) a = ACT_NOP;
				else a = ACT_WRITE;
				if ($urandom_range(0, 9) == 0) run_slot = !run_slot;
				plan(a, (a == ACT_GOOD && $urandom_range(0, 2) != 0) ? run_slot : 1'($urandom),
					run_slot, $urandom_range(0, 11) != 0, 5'($urandom), 8'($urandom), 1'b0);
			end
		end
		total_items = cmd_backlog.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (n_accepted < total_items || slot_reports_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("tb: %0d transactions checked over reloads, slot commands and queries", n_accepted);
		$display("tb: %0d transactions answered with a nonzero status", n_refused);
		if (mismatches == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/absme_pkg.sv
sv/absme_crc_unit.sv
sv/absme_record.sv
sv/ab_boot_slot_metadata_engine.sv
tb/tb.sv
